// ===== rtl/core/adcdc_pkg.sv =====
// Shared constants, types and codes for the ADC DC offset tracker.
// Used by adcdc_front, adcdc_back and adc_dc_offset_tracker_top; no dependencies.
package adcdc_pkg;

  localparam int BLOCK_SAMPLES = 1024;
  localparam int COUNT_WIDTH   = 24;
  // centered values span 17 signed bits; total holds COUNT_MAX of them
  localparam int TOTAL_WIDTH   = COUNT_WIDTH + 18;
  localparam int POS_WIDTH     = $clog2(BLOCK_SAMPLES);
  localparam int ITER_WIDTH    = $clog2(TOTAL_WIDTH);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_WIDTH    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
  localparam logic [15:0]            RESET_OFFSET = 16'd32768;
  localparam logic [15:0]            RESET_PERIOD = 16'd9999;
  localparam logic [15:0]            ELAPSED_MAX  = 16'hFFFF;

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // register select (address bit 2)
  localparam logic REG_INIT_OFFSET = 1'b0;
  localparam logic REG_PERIOD      = 1'b1;

  typedef struct packed {
    logic        tick;
    logic [15:0] sample;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic        load_offset;
    logic [15:0] offset_value;
    logic [15:0] period;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_ADJ
  } state_t;

endpackage

// ===== rtl/core/adcdc_front.sv =====
// Front end: accepts input beats, drops samples taken while transmitting,
// and queues ticks and samples in order. Depends on adcdc_pkg.
module adcdc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [15:0]          adc_sample,
  input  logic                 transmitting,
  output adcdc_pkg::queue_head_t head,
  input  logic                 pop
);

  adcdc_pkg::queue_entry_t entries [adcdc_pkg::QUEUE_DEPTH];
  logic [adcdc_pkg::QPTR_WIDTH-1:0] wr_ptr;
  logic [adcdc_pkg::QPTR_WIDTH-1:0] rd_ptr;
  logic [adcdc_pkg::QPTR_WIDTH:0]   fill;
  logic                             keep;
  logic                             push;
  logic                             do_pop;

  assign in_ready = (fill != (adcdc_pkg::QPTR_WIDTH + 1)'(adcdc_pkg::QUEUE_DEPTH));
  // ticks always count; samples during transmit are swallowed
  assign keep     = (operation == adcdc_pkg::OP_TICK) || !transmitting;
  assign push     = in_valid && in_ready && keep;
  assign do_pop   = pop && head.valid;

  assign head.valid = (fill != '0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == adcdc_pkg::QPTR_WIDTH'(adcdc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == adcdc_pkg::QPTR_WIDTH'(adcdc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].tick   <= (operation == adcdc_pkg::OP_TICK);
      entries[wr_ptr].sample <= adc_sample;
    end
  end

endmodule

// ===== rtl/core/adcdc_back.sv =====
// Back end: centers samples, tracks peaks, total, count and timer, and runs
// the bit-serial average divider at adjusting block ends. Depends on adcdc_pkg.
module adcdc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  adcdc_pkg::queue_head_t head,
  output logic                   pop,
  input  adcdc_pkg::cfg_t        cfg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     centered_sample,
  output logic                   block_done,
  output logic [15:0]            block_peak_high,
  output logic signed [16:0]     block_peak_low,
  output logic                   offset_updated,
  output logic signed [16:0]     average_error,
  output logic [15:0]            new_offset
);

  localparam int TW = adcdc_pkg::TOTAL_WIDTH;
  localparam int CW = adcdc_pkg::COUNT_WIDTH;

  adcdc_pkg::state_t state, state_next;

  logic [15:0]                      offset, offset_next;
  logic signed [16:0]               peak_high, peak_high_next;
  logic signed [16:0]               peak_low, peak_low_next;
  logic signed [TW-1:0]             total, total_next;
  logic [CW-1:0]                    count, count_next;
  logic [adcdc_pkg::POS_WIDTH-1:0]  position, position_next;
  logic [15:0]                      elapsed, elapsed_next;

  logic [CW:0]                      rem, rem_next;
  logic [TW-1:0]                    dvd, dvd_next;
  logic [CW-1:0]                    divisor, divisor_next;
  logic                             neg, neg_next;
  logic [adcdc_pkg::ITER_WIDTH-1:0] iter, iter_next;

  logic                             out_valid_next;
  logic signed [15:0]               centered_next;
  logic                             done_next;
  logic [15:0]                      peak_high_out_next;
  logic signed [16:0]               peak_low_out_next;
  logic                             updated_next;
  logic signed [16:0]               average_next;
  logic [15:0]                      new_offset_next;

  logic                             slot_free;
  logic signed [16:0]               centered;
  logic signed [15:0]               centered_sat;
  logic signed [16:0]               ph_new;
  logic signed [16:0]               pl_new;
  logic                             count_full;
  logic signed [TW-1:0]             total_sum;
  logic [CW-1:0]                    count_inc;
  logic [TW-1:0]                    total_mag;
  logic                             block_end;
  logic                             adjust;
  logic [CW:0]                      rem_shift;
  logic                             fits;
  logic signed [16:0]               avg;
  logic signed [17:0]               offset_sum;
  logic [15:0]                      offset_sat;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    centered = $signed({1'b0, head.entry.sample}) - $signed({1'b0, offset});
    if (centered > 17'sd32767) begin
      centered_sat = 16'sh7FFF;
    end else if (centered < -17'sd32768) begin
      centered_sat = 16'sh8000;
    end else begin
      centered_sat = centered[15:0];
    end
    ph_new     = (centered > peak_high) ? centered : peak_high;
    pl_new     = (centered < peak_low) ? centered : peak_low;
    count_full = (count == adcdc_pkg::COUNT_MAX);
    total_sum  = count_full ? total : total + {{(TW - 17){centered[16]}}, centered};
    count_inc  = count_full ? count : count + 1'b1;
    total_mag  = total_sum[TW-1] ? 0 - total_sum : total_sum;
    block_end  = (position == adcdc_pkg::POS_WIDTH'(adcdc_pkg::BLOCK_SAMPLES - 1));
    adjust     = (elapsed > cfg.period);

    // one restoring step per cycle
    rem_shift  = {rem[CW-1:0], dvd[TW-1]};
    fits       = (rem_shift >= {1'b0, divisor});

    avg        = neg ? 17'sd0 - $signed(dvd[16:0]) : $signed(dvd[16:0]);
    offset_sum = $signed({2'b00, offset}) + $signed({avg[16], avg});
    if (offset_sum < 18'sd0) begin
      offset_sat = 16'd0;
    end else if (offset_sum > 18'sd65535) begin
      offset_sat = 16'hFFFF;
    end else begin
      offset_sat = offset_sum[15:0];
    end
  end

  always_comb begin
    state_next         = state;
    offset_next        = offset;
    peak_high_next     = peak_high;
    peak_low_next      = peak_low;
    total_next         = total;
    count_next         = count;
    position_next      = position;
    elapsed_next       = elapsed;
    rem_next           = rem;
    dvd_next           = dvd;
    divisor_next       = divisor;
    neg_next           = neg;
    iter_next          = iter;
    out_valid_next     = out_valid && !out_ready;
    centered_next      = centered_sample;
    done_next          = block_done;
    peak_high_out_next = block_peak_high;
    peak_low_out_next  = block_peak_low;
    updated_next       = offset_updated;
    average_next       = average_error;
    new_offset_next    = new_offset;
    pop                = 1'b0;

    unique case (state)
      adcdc_pkg::ST_RUN: begin
        if (head.valid && (head.entry.tick || slot_free)) begin
          pop = 1'b1;
          if (head.entry.tick) begin
            if (elapsed != adcdc_pkg::ELAPSED_MAX) begin
              elapsed_next = elapsed + 1'b1;
            end
          end else begin
            total_next         = total_sum;
            count_next         = count_inc;
            centered_next      = centered_sat;
            done_next          = 1'b0;
            peak_high_out_next = '0;
            peak_low_out_next  = '0;
            updated_next       = 1'b0;
            average_next       = '0;
            new_offset_next    = '0;
            out_valid_next     = 1'b1;
            if (block_end) begin
              position_next      = '0;
              peak_high_next     = '0;
              peak_low_next      = '0;
              done_next          = 1'b1;
              peak_high_out_next = ph_new[15:0];
              peak_low_out_next  = pl_new;
              if (adjust) begin
                // hold the result until the average is ready
                out_valid_next = 1'b0;
                total_next     = '0;
                count_next     = '0;
                elapsed_next   = '0;
                rem_next       = '0;
                dvd_next       = total_mag;
                divisor_next   = count_inc;
                neg_next       = total_sum[TW-1];
                iter_next      = adcdc_pkg::ITER_WIDTH'(TW - 1);
                state_next     = adcdc_pkg::ST_DIV;
              end
            end else begin
              position_next  = position + 1'b1;
              peak_high_next = ph_new;
              peak_low_next  = pl_new;
            end
          end
        end
      end
      adcdc_pkg::ST_DIV: begin
        rem_next = fits ? rem_shift - {1'b0, divisor} : rem_shift;
        dvd_next = {dvd[TW-2:0], fits};
        if (iter == '0) begin
          state_next = adcdc_pkg::ST_ADJ;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      adcdc_pkg::ST_ADJ: begin
        offset_next     = offset_sat;
        updated_next    = 1'b1;
        average_next    = avg;
        new_offset_next = offset_sat;
        out_valid_next  = 1'b1;
        state_next      = adcdc_pkg::ST_RUN;
      end
      default: begin
        state_next = adcdc_pkg::ST_RUN;
      end
    endcase

    if (cfg.load_offset) begin
      offset_next = cfg.offset_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adcdc_pkg::ST_RUN;
      offset    <= adcdc_pkg::RESET_OFFSET;
      peak_high <= '0;
      peak_low  <= '0;
      total     <= '0;
      count     <= '0;
      position  <= '0;
      elapsed   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      offset    <= offset_next;
      peak_high <= peak_high_next;
      peak_low  <= peak_low_next;
      total     <= total_next;
      count     <= count_next;
      position  <= position_next;
      elapsed   <= elapsed_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem             <= rem_next;
    dvd             <= dvd_next;
    divisor         <= divisor_next;
    neg             <= neg_next;
    iter            <= iter_next;
    centered_sample <= centered_next;
    block_done      <= done_next;
    block_peak_high <= peak_high_out_next;
    block_peak_low  <= peak_low_out_next;
    offset_updated  <= updated_next;
    average_error   <= average_next;
    new_offset      <= new_offset_next;
  end

endmodule

// ===== rtl/core/adc_dc_offset_tracker_top.sv =====
// A kept sample's beat is queued in the front end, then popped by the back end, which registers
// its result; a block end that adjusts the offset first runs the bit-serial divider (ST_DIV,
// then ST_ADJ), one quotient bit per cycle. Throughput: one beat per cycle while out_ready
// is high, except that the back end holds while the divider runs at an adjusting block end.
// Reset (rst, synchronous): queue, counters, peaks and timer clear; offset 32768,
// period 9999.
module adc_dc_offset_tracker_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [15:0]        adc_sample,
  input  logic               transmitting,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] centered_sample,
  output logic               block_done,
  output logic [15:0]        block_peak_high,
  output logic signed [16:0] block_peak_low,
  output logic               offset_updated,
  output logic signed [16:0] average_error,
  output logic [15:0]        new_offset
);

  logic [15:0]            initial_offset;
  logic [15:0]            adjust_period_ms;
  logic                   cfg_write;
  adcdc_pkg::cfg_t        cfg;
  adcdc_pkg::queue_head_t head;
  logic                   pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_offset   <= adcdc_pkg::RESET_OFFSET;
      adjust_period_ms <= adcdc_pkg::RESET_PERIOD;
    end else if (cfg_write) begin
      unique case (paddr[2])
        adcdc_pkg::REG_INIT_OFFSET: initial_offset   <= pwdata[15:0];
        adcdc_pkg::REG_PERIOD:      adjust_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      adcdc_pkg::REG_INIT_OFFSET: prdata = {16'd0, initial_offset};
      adcdc_pkg::REG_PERIOD:      prdata = {16'd0, adjust_period_ms};
      default:                    prdata = '0;
    endcase
  end

  // an offset write also reloads the working offset
  assign cfg.load_offset  = cfg_write && (paddr[2] == adcdc_pkg::REG_INIT_OFFSET);
  assign cfg.offset_value = pwdata[15:0];
  assign cfg.period       = adjust_period_ms;

  adcdc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .adc_sample   (adc_sample),
    .transmitting (transmitting),
    .head         (head),
    .pop          (pop)
  );

  adcdc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .centered_sample (centered_sample),
    .block_done      (block_done),
    .block_peak_high (block_peak_high),
    .block_peak_low  (block_peak_low),
    .offset_updated  (offset_updated),
    .average_error   (average_error),
    .new_offset      (new_offset)
  );

endmodule

// ===== dv/adc_dc_offset_tracker_top_tb.sv =====
// Self-checking testbench for adc_dc_offset_tracker_top: directed table, then random phases.
// Depends on adcdc_pkg and the RTL top; the expected results come from an in-bench tracker.
`timescale 1ns / 1ps

module adc_dc_offset_tracker_top_tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_LEN   = 64;
  localparam int PHASE_ITEMS  = 270;
  localparam int NUM_PHASES   = 4;

  typedef struct packed {
    logic        op;
    logic [15:0] smp;
    logic        tx;
  } tracker_item_t;

  typedef struct packed {
    logic signed [15:0] centered;
    logic               done;
    logic [15:0]        peak_hi;
    logic signed [16:0] peak_lo;
    logic               upd;
    logic signed [16:0] avg;
    logic [15:0]        new_off;
  } tracker_result_t;

  // typed = 1: the centered value below is the known answer, all other fields zero
  typedef struct packed {
    logic               op;
    logic [15:0]        smp;
    logic               tx;
    logic               typed;
    logic signed [15:0] centered;
  } dir_row_t;

  localparam int DIR_LEN = 16;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{adcdc_pkg::OP_SAMPLE, 16'd32768, 1'b0, 1'b1, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'd0,     1'b0, 1'b1, -16'sd32768},
    '{adcdc_pkg::OP_SAMPLE, 16'd65535, 1'b0, 1'b1, 16'sd32767},
    '{adcdc_pkg::OP_SAMPLE, 16'd32767, 1'b0, 1'b1, -16'sd1},
    '{adcdc_pkg::OP_SAMPLE, 16'd32769, 1'b0, 1'b1, 16'sd1},
    '{adcdc_pkg::OP_TICK,   16'd0,     1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_TICK,   16'hFFFF,  1'b1, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'd0,     1'b1, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'hFFFF,  1'b1, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'hAAAA,  1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'h5555,  1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_TICK,   16'h5555,  1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'h8001,  1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'h7FFE,  1'b1, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'h0001,  1'b0, 1'b0, 16'sd0},
    '{adcdc_pkg::OP_SAMPLE, 16'hFFFE,  1'b0, 1'b0, 16'sd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = adcdc_pkg::OP_SAMPLE;
  logic [15:0]        adc_sample = '0;
  logic               transmitting = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic signed [15:0] centered_sample;
  logic               block_done;
  logic [15:0]        block_peak_high;
  logic signed [16:0] block_peak_low;
  logic               offset_updated;
  logic signed [16:0] average_error;
  logic [15:0]        new_offset;

  adc_dc_offset_tracker_top u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .adc_sample      (adc_sample),
    .transmitting    (transmitting),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .centered_sample (centered_sample),
    .block_done      (block_done),
    .block_peak_high (block_peak_high),
    .block_peak_low  (block_peak_low),
    .offset_updated  (offset_updated),
    .average_error   (average_error),
    .new_offset      (new_offset)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracker state, mirrored from the block
  logic [15:0] trk_offset = adcdc_pkg::RESET_OFFSET;
  logic [15:0] trk_period = adcdc_pkg::RESET_PERIOD;
  int          trk_peak_hi = 0;
  int          trk_peak_lo = 0;
  longint      trk_total = 0;
  longint      trk_count = 0;
  int          trk_pos = 0;
  int          trk_elapsed = 0;

  tracker_result_t pending_results [$];
  int mismatches = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic bit track_item(input tracker_item_t it, output tracker_result_t r);
    int     centered;
    longint avg;
    longint next;
    r = '0;
    if (it.op == adcdc_pkg::OP_TICK) begin
      if (trk_elapsed < int'(adcdc_pkg::ELAPSED_MAX))
        trk_elapsed++;
      return 1'b0;
    end
    if (it.tx)
      return 1'b0;
    centered = int'(it.smp) - int'(trk_offset);
    if (centered > 32767)
      r.centered = 16'sd32767;
    else if (centered < -32768)
      r.centered = -16'sd32768;
    else
      r.centered = centered[15:0];
    if (centered > trk_peak_hi)
      trk_peak_hi = centered;
    if (centered < trk_peak_lo)
      trk_peak_lo = centered;
    if (trk_count < longint'(adcdc_pkg::COUNT_MAX)) begin
      trk_total += centered;
      trk_count++;
    end
    trk_pos++;
    if (trk_pos >= adcdc_pkg::BLOCK_SAMPLES) begin
      trk_pos = 0;
      r.done = 1'b1;
      r.peak_hi = trk_peak_hi[15:0];
      r.peak_lo = trk_peak_lo[16:0];
      if (trk_elapsed > int'(trk_period)) begin
        avg = (trk_count != 0) ? trk_total / trk_count : 0;
        next = longint'(trk_offset) + avg;
        if (next < 0)
          next = 0;
        if (next > 65535)
          next = 65535;
        trk_offset = next[15:0];
        trk_total = 0;
        trk_count = 0;
        trk_elapsed = 0;
        r.upd = 1'b1;
        r.avg = avg[16:0];
        r.new_off = next[15:0];
      end
      trk_peak_hi = 0;
      trk_peak_lo = 0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == adcdc_pkg::REG_INIT_OFFSET)
      trk_offset = value;
    else
      trk_period = value;
  endtask

  // hold the beat until taken, then record what it should produce
  task automatic send_item(input tracker_item_t it, input bit typed,
                           input tracker_result_t known);
    int gap;
    tracker_result_t r;
    gap = 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    adc_sample <= it.smp;
    transmitting <= it.tx;
    do @(posedge clk); while (!in_ready);
    if (track_item(it, r))
      pending_results.push_back(typed ? known : r);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    // ticks and dropped samples leave no result; give them time to clear
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 10)
      return sel[0] ? 16'hFFFF : 16'h0000;
    if (sel < 50) begin
      v = int'(trk_offset) + int'($urandom_range(512)) - 256;
      if (v < 0)
        v = 0;
      if (v > 65535)
        v = 65535;
      return v[15:0];
    end
    return 16'($urandom());
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got centered %0d", $time,
                 centered_sample);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("centered_sample", longint'(want.centered), longint'(centered_sample));
        check_field("block_done", longint'(want.done), longint'(block_done));
        check_field("block_peak_high", longint'(want.peak_hi), longint'(block_peak_high));
        check_field("block_peak_low", longint'(want.peak_lo), longint'(block_peak_low));
        check_field("offset_updated", longint'(want.upd), longint'(offset_updated));
        check_field("average_error", longint'(want.avg), longint'(average_error));
        check_field("new_offset", longint'(want.new_off), longint'(new_offset));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("adc_dc_offset_tracker_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    tracker_item_t   it;
    tracker_result_t known;
    int              done_items;
    int              kind;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_LEN; i++) begin
      it.op = DIR_ROWS[i].op;
      it.smp = DIR_ROWS[i].smp;
      it.tx = DIR_ROWS[i].tx;
      known = '0;
      known.centered = DIR_ROWS[i].centered;
      send_item(it, DIR_ROWS[i].typed, known);
    end
    drain_and_settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(adcdc_pkg::REG_INIT_OFFSET, 16'd0);
          write_reg(adcdc_pkg::REG_PERIOD, 16'd1);
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(adcdc_pkg::REG_INIT_OFFSET, 16'hFFFF);
          write_reg(adcdc_pkg::REG_PERIOD, 16'hFFFF);
          gap_pct = 66;
          stall_pct = 0;
        end
        2: begin
          write_reg(adcdc_pkg::REG_INIT_OFFSET, 16'($urandom()));
          write_reg(adcdc_pkg::REG_PERIOD, 16'd0);
          gap_pct = 0;
          stall_pct = 66;
        end
        default: begin
          write_reg(adcdc_pkg::REG_INIT_OFFSET, 16'($urandom()));
          write_reg(adcdc_pkg::REG_PERIOD, 16'($urandom_range(60, 1)));
          gap_pct = 11;
          stall_pct = 11;
        end
      endcase
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        it.op = adcdc_pkg::OP_SAMPLE;
        it.smp = pick_sample();
        it.tx = 1'b0;
        if (kind < 5) begin
          it.op = adcdc_pkg::OP_TICK;
          it.tx = 1'($urandom_range(1));
        end else if (kind < 9) begin
          it.tx = 1'b1;
        end
        send_item(it, 1'b0, '0);
        if (it.op == adcdc_pkg::OP_TICK || !it.tx)
          done_items++;
      end
      drain_and_settle();
    end

    if (mismatches == 0)
      $display("adc_dc_offset_tracker_top_tb OK");
    else
      $display("adc_dc_offset_tracker_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/adcdc_pkg.sv
rtl/core/adcdc_front.sv
rtl/core/adcdc_back.sv
rtl/core/adc_dc_offset_tracker_top.sv
dv/adc_dc_offset_tracker_top_tb.sv
